/* rtl/cooccurrence_window_pair_emitter_macros.svh */
// Assertion macros shared by the cooccurrence pair emitter RTL.
`ifndef COOCCURRENCE_WINDOW_PAIR_EMITTER_MACROS_SVH
`define COOCCURRENCE_WINDOW_PAIR_EMITTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CWPE_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define CWPE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/cwpe_pkg.sv */
// Types, codes and constants of the cooccurrence pair emitter.
`timescale 1ns / 1ps
package cwpe_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int ID_W           = 32;
    localparam int WIN_W          = 5;
    localparam int WEIGHT_W       = 17;
    localparam int CMD_W          = 2;
    localparam int IN_TUSER_W     = 3;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 88;
    localparam int OUT_PAD_W      = OUT_TDATA_W - 2 * ID_W - WEIGHT_W;
    localparam int CFG_IDX_W      = 1;
    localparam int RECIP_DEPTH    = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd15;

    typedef enum logic [CMD_W-1:0] {
        CMD_WORD       = 2'd0,
        CMD_SENT_START = 2'd1,
        CMD_SENT_END   = 2'd2,
        CMD_NEW_DOC    = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_ON_TAGS = 1'b1;

    // round(65536 / d), entry d-1
    localparam logic [WEIGHT_W-1:0] RECIP_TABLE [0:RECIP_DEPTH-1] = '{
        17'd65536, 17'd32768, 17'd21845, 17'd16384,
        17'd13107, 17'd10923, 17'd9362,  17'd8192,
        17'd7282,  17'd6554,  17'd5958,  17'd5461,
        17'd5041,  17'd4681,  17'd4369,  17'd4096,
        17'd3855,  17'd3641,  17'd3449,  17'd3277,
        17'd3121,  17'd2979,  17'd2849,  17'd2731,
        17'd2621,  17'd2521,  17'd2427,  17'd2341,
        17'd2260,  17'd2185,  17'd2114,  17'd2048
    };

endpackage

/* rtl/cwpe_hist_ram.sv */
// History id memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cwpe_hist_ram #(
    parameter int DEPTH = cwpe_pkg::WINDOW_MAX_DEF,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [cwpe_pkg::ID_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [cwpe_pkg::ID_W-1:0] o_rd_data
);
    import cwpe_pkg::*;

    logic [ID_W-1:0] r_mem [0:DEPTH-1];
    logic [ID_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/cooccurrence_window_pair_emitter.sv */
// Top level of the cooccurrence window pair emitter.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+------------------------------
//  s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready  | tdata token_id, tuser cmd,vocab
//  m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready  | tdata target,context,weight; tlast
//  cfg      | in        | i_cfg_wr_en                      | i_cfg_index, i_cfg_wdata
//
//  An item that emits nothing is handled in S_IDLE. A counted token over a history of n ids
//  takes one history memory read then two results per id, then one push step.
//  The sequencer walks the history memory one entry per read; a stalled result holds it.
//  Reset is synchronous: history empty, window 15, tag breaking on. No clearing pass.
`timescale 1ns / 1ps
`include "cooccurrence_window_pair_emitter_macros.svh"
module cooccurrence_window_pair_emitter #(
    parameter int WINDOW_MAX = cwpe_pkg::WINDOW_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [31:0] token_id
    input  logic [cwpe_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd, [2] in_vocab
    input  logic [cwpe_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] target_id, [63:32] context_id, [80:64] weight, [87:81] zero
    output logic [cwpe_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_wr_en,
    input  logic [cwpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cwpe_pkg::WIN_W-1:0]       i_cfg_wdata
);
    import cwpe_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = CW + 1;
    localparam int EW = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PAIR_A,
        S_PAIR_B,
        S_PUSH
    } t_state;

    t_state              r_state;
    logic [WIN_W-1:0]    r_window;
    logic                r_break;
    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [ID_W-1:0]     r_tid;
    logic [AW-1:0]       r_rd_addr;
    logic [CW-1:0]       r_dist;
    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_target;
    logic [ID_W-1:0]     r_out_context;
    logic [WEIGHT_W-1:0] r_out_weight;
    logic                r_out_last;

    t_cmd                in_cmd;
    logic                in_vocab;
    logic                in_fire;
    logic                in_clear;
    logic                in_counted;
    logic                in_walk;
    logic                out_free;
    logic                out_emit;
    logic [ID_W-1:0]     rd_data;
    logic [EW-1:0]       w_eff;
    logic                hist_full;
    logic                do_push;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ID_W-1:0]     wr_data;
    logic [AW-1:0]       n_head;
    logic [CW-1:0]       n_count;
    logic [WEIGHT_W-1:0] weight;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(WINDOW_MAX)) begin
            sum = sum - SW'(WINDOW_MAX);
        end
        return AW'(sum);
    endfunction

    assign in_cmd   = t_cmd'(i_s_axis_tuser[CMD_W-1:0]);
    assign in_vocab = i_s_axis_tuser[CMD_W];
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_clear = (in_cmd == CMD_NEW_DOC) || (r_break && (in_cmd == CMD_SENT_START));
    assign in_counted = in_vocab && (in_cmd != CMD_NEW_DOC) &&
                        !(r_break && ((in_cmd == CMD_SENT_START) ||
                                      (in_cmd == CMD_SENT_END)));
    assign in_walk  = (r_state == S_READ) || (r_state == S_PAIR_A) || (r_state == S_PAIR_B);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign out_emit = out_free && ((r_state == S_PAIR_A) || (r_state == S_PAIR_B));

    assign w_eff     = (EW'(r_window) > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : EW'(r_window);
    assign hist_full = EW'(r_count) >= w_eff;
    assign do_push   = (r_state == S_PUSH) ||
                       ((r_state == S_IDLE) && in_fire && in_counted && (r_count == '0));
    assign wr_en     = do_push && !(hist_full && (r_count == '0));
    assign wr_addr   = wrap_add(r_head, r_count);
    assign wr_data   = (r_state == S_PUSH) ? r_tid : i_s_axis_tdata;
    assign n_head    = hist_full ? wrap_add(r_head, CW'(1)) : r_head;
    assign n_count   = hist_full ? r_count : r_count + CW'(1);
    assign weight    = RECIP_TABLE[5'(r_dist - CW'(1))];

    cwpe_hist_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_break     <= 1'b1;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_WINDOW_SIZE:   r_window <= i_cfg_wdata;
                    REG_BREAK_ON_TAGS: r_break  <= i_cfg_wdata[0];
                endcase
            end
            if (out_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_tid     <= i_s_axis_tdata;
                        r_rd_addr <= r_head;
                        r_dist    <= r_count;
                        if (in_clear) begin
                            r_count <= '0;
                        end else if (in_counted && (r_count != '0)) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_PAIR_A;
                end
                S_PAIR_A: begin
                    if (out_free) begin
                        r_out_target  <= r_tid;
                        r_out_context <= rd_data;
                        r_out_weight  <= weight;
                        r_out_last    <= 1'b0;
                        r_state       <= S_PAIR_B;
                    end
                end
                S_PAIR_B: begin
                    if (out_free) begin
                        r_out_target  <= rd_data;
                        r_out_context <= r_tid;
                        r_out_weight  <= weight;
                        r_out_last    <= (r_dist == CW'(1));
                        if (r_dist == CW'(1)) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_dist    <= r_dist - CW'(1);
                            r_rd_addr <= wrap_add(r_rd_addr, CW'(1));
                            r_state   <= S_READ;
                        end
                    end
                end
                S_PUSH: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_weight, r_out_context, r_out_target};
    assign o_m_axis_tlast  = r_out_last;

    `CWPE_ASSERT_IMPL(a_count_bound, 1'b1, int'(r_count) <= WINDOW_MAX, "history count overflow")
    `CWPE_ASSERT_IMPL(a_head_bound, 1'b1, int'(r_head) < WINDOW_MAX, "history head out of range")
    `CWPE_ASSERT_IMPL(a_dist_range, in_walk, (r_dist != '0) && (r_dist <= r_count), "bad distance")
    `CWPE_ASSERT_NEXT(a_push_done, r_state == S_PUSH, r_state == S_IDLE, "push did not return")

endmodule
